@@ design/lcmt_pkg.sv @@
// Shared types and codes for the line minimum tree.
`default_nettype none
package lcmt_pkg;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] REG_MAX_MODE   = 2'd0;
	localparam logic [1:0] REG_NEUTRAL    = 2'd1;
	localparam logic [1:0] REG_POINT_CNT  = 2'd2;

	// One classified request. For a load, a holds the point value; for an
	// add, a and b hold the (possibly negated) slope and intercept.
	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  idx;
		logic [63:0] a;
		logic [63:0] b;
	} cmd_t;

	typedef struct packed {
		logic        max_mode;
		logic [63:0] neutral;
		logic [10:0] point_count;
	} cfg_t;

endpackage
`default_nettype wire

@@ design/lcmt_front.sv @@
// Front stage: accepts requests, drops those that do nothing, negates lines in max mode.
`default_nettype none
module lcmt_front #(
	parameter int MAX_POINTS = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                max_mode,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         in_kind,
	input  wire  [9:0]         in_idx,
	input  wire  [63:0]        in_value,
	input  wire  [63:0]        in_slope,
	input  wire  [63:0]        in_icpt,
	output logic               push,
	output lcmt_pkg::cmd_t     cmd,
	input  wire                push_ready
);

	logic           vld_q;
	lcmt_pkg::cmd_t cmd_q;
	logic           keep;
	lcmt_pkg::cmd_t next_cmd;

	assign in_ready = !vld_q || push_ready;
	assign push     = vld_q;
	assign cmd      = cmd_q;

	always_comb begin
		next_cmd.op  = in_kind;
		next_cmd.idx = in_idx;
		next_cmd.a   = in_value;
		next_cmd.b   = 64'd0;
		keep         = 1'b1;
		case (in_kind)
			lcmt_pkg::OP_LOAD: begin
				keep = (32'(in_idx) < MAX_POINTS);
			end
			lcmt_pkg::OP_ADD: begin
				next_cmd.a = max_mode ? (64'd0 - in_slope) : in_slope;
				next_cmd.b = max_mode ? (64'd0 - in_icpt) : in_icpt;
			end
			lcmt_pkg::OP_QUERY: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= next_cmd;
		end
	end

endmodule
`default_nettype wire

@@ design/lcmt_fifo.sv @@
// Two-entry request queue between the front and the tree walker.
`default_nettype none
module lcmt_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  lcmt_pkg::cmd_t     din,
	output logic               ready,
	output logic               valid,
	output lcmt_pkg::cmd_t     dout,
	input  wire                pop
);

	lcmt_pkg::cmd_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign ready   = (cnt_q != 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign dout    = mem_q[rp_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ design/lcmt_back.sv @@
// Tree walker: point store, node memory, shared multiplier and the answer register.
`default_nettype none
module lcmt_back #(
	parameter int MAX_POINTS = 1024,
	parameter int TREE_NODES = 4096
) (
	input  wire                clk,
	input  wire                arst_n,
	input  lcmt_pkg::cfg_t     cfg,
	input  wire                cmd_valid,
	input  lcmt_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [63:0]        out_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int NW = $clog2(TREE_NODES);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_WALK   = 4'd2;
	localparam logic [3:0] ST_FETCH2 = 4'd3;
	localparam logic [3:0] ST_FETCH3 = 4'd4;
	localparam logic [3:0] ST_EVAL   = 4'd5;
	localparam logic [3:0] ST_DECIDE = 4'd6;
	localparam logic [3:0] ST_DONE   = 4'd7;

	logic [3:0]    st_q;
	logic [NW-1:0] clr_q;
	logic          isq_q;
	logic          have_q;
	logic [PW-1:0] i_q, lx_q, rx_q;
	logic [NW-1:0] x_q;
	logic [63:0]   nk_q, nb_q, tk_q, tb_q, p0_q, p1_q;
	logic [1:0]    ev_q, ph_q;
	logic [63:0]   prod_q, acc_q, best_q;
	logic [63:0]   v_q [4];
	logic          ovld_q;
	logic [63:0]   odata_q;

	logic [63:0]   pt_mem [MAX_POINTS];
	logic [63:0]   pt_rd_q;
	logic [63:0]   slope_mem [TREE_NODES];
	logic [63:0]   icpt_mem [TREE_NODES];
	logic          wrt_mem [TREE_NODES];
	logic [63:0]   nd_k_q, nd_b_q;
	logic          nd_w_q;

	logic [PW-1:0] leaves, qi, m;
	logic [PW:0]   msum;
	logic          last_lvl;
	logic [NW+1:0] nx_l, nx_r, nx;
	logic          go_right, stop;
	logic          left_lt, mid_lt;
	logic          pt_re, nd_we;
	logic [PW-1:0] pt_ra_w;
	logic          use_node;
	logic [63:0]   ek, eb, ex;
	logic [31:0]   ma, mb;
	logic          ev_last;
	logic [63:0]   vq_new;

	// Leaf count from the register: zero acts as one, larger than the store saturates.
	always_comb begin
		if (cfg.point_count == 11'd0) leaves = PW'(1);
		else if (32'(cfg.point_count) > MAX_POINTS) leaves = PW'(MAX_POINTS);
		else leaves = PW'(cfg.point_count);
		if (32'(cmd.idx) >= MAX_POINTS) qi = PW'(MAX_POINTS - 1);
		else qi = PW'(cmd.idx);
	end

	assign msum     = {1'b0, lx_q} + {1'b0, rx_q};
	assign m        = msum[PW:1];
	assign last_lvl = ((rx_q - lx_q) <= PW'(1));
	assign left_lt  = $signed(v_q[0]) < $signed(v_q[1]);
	assign mid_lt   = $signed(v_q[2]) < $signed(v_q[3]);
	assign nx_l     = ({2'b00, x_q} << 1) + (NW+2)'(1);
	assign nx_r     = ({2'b00, x_q} << 1) + (NW+2)'(2);
	assign go_right = isq_q ? !(i_q < m) : (left_lt == mid_lt);
	assign nx       = go_right ? nx_r : nx_l;
	assign stop     = last_lvl || (32'(nx) >= TREE_NODES);

	assign cmd_pop  = (st_q == ST_IDLE) && cmd_valid;
	assign pt_re    = (st_q == ST_WALK) || (st_q == ST_FETCH2);
	assign pt_ra_w  = (st_q == ST_WALK) ? (isq_q ? i_q : lx_q) : m;
	assign nd_we    = (st_q == ST_CLEAR) || ((st_q == ST_DECIDE) && !isq_q && mid_lt);

	// Point store.
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op == lcmt_pkg::OP_LOAD)) begin
			pt_mem[AW'(cmd.idx)] <= cmd.a;
		end
		if (pt_re) begin
			pt_rd_q <= pt_mem[AW'(pt_ra_w)];
		end
	end

	// Node memory with its written flag; the clearing pass writes zero flags.
	always_ff @(posedge clk) begin
		if (nd_we) begin
			slope_mem[(st_q == ST_CLEAR) ? clr_q : x_q] <= nk_q;
			icpt_mem[(st_q == ST_CLEAR) ? clr_q : x_q]  <= nb_q;
			wrt_mem[(st_q == ST_CLEAR) ? clr_q : x_q]   <= (st_q != ST_CLEAR);
		end
		if (st_q == ST_WALK) begin
			nd_k_q <= slope_mem[x_q];
			nd_b_q <= icpt_mem[x_q];
			nd_w_q <= wrt_mem[x_q];
		end
	end

	// Operand choice for the 64-bit wrap-around product, one 32x32 partial a cycle.
	assign use_node = isq_q || ev_q[0];
	assign ek       = use_node ? tk_q : nk_q;
	assign eb       = use_node ? tb_q : nb_q;
	assign ex       = ev_q[1] ? p1_q : p0_q;
	assign ev_last  = isq_q || (ev_q == 2'd3);
	assign vq_new   = acc_q + {prod_q[31:0], 32'd0};

	always_comb begin
		case (ph_q)
			2'd0: begin
				ma = ek[31:0];
				mb = ex[31:0];
			end
			2'd1: begin
				ma = ek[63:32];
				mb = ex[31:0];
			end
			2'd2: begin
				ma = ek[31:0];
				mb = ex[63:32];
			end
			default: begin
				ma = 32'd0;
				mb = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EVAL) begin
			prod_q <= {32'd0, ma} * {32'd0, mb};
			case (ph_q)
				2'd1: acc_q <= prod_q + eb;
				2'd2: acc_q <= vq_new;
				2'd3: v_q[ev_q] <= vq_new;
				default: acc_q <= acc_q;
			endcase
		end
		if (st_q == ST_FETCH2) begin
			tk_q <= nd_w_q ? nd_k_q : 64'd0;
			tb_q <= nd_w_q ? nd_b_q : cfg.neutral;
			p0_q <= pt_rd_q;
		end
		if (st_q == ST_FETCH3) begin
			p1_q <= pt_rd_q;
		end
		if (cmd_pop) begin
			nk_q <= cmd.a;
			nb_q <= cmd.b;
		end else if ((st_q == ST_DECIDE) && !isq_q && mid_lt) begin
			nk_q <= tk_q;
			nb_q <= tb_q;
		end else if (st_q == ST_CLEAR) begin
			nk_q <= 64'd0;
			nb_q <= 64'd0;
		end
		if ((st_q == ST_DECIDE) && isq_q) begin
			if (!have_q || ($signed(v_q[0]) < $signed(best_q))) best_q <= v_q[0];
		end
		if ((st_q == ST_DONE) && (!ovld_q || out_ready)) begin
			odata_q <= cfg.max_mode ? (64'd0 - best_q) : best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			isq_q  <= 1'b0;
			have_q <= 1'b0;
			i_q    <= '0;
			lx_q   <= '0;
			rx_q   <= '0;
			x_q    <= '0;
			ev_q   <= 2'd0;
			ph_q   <= 2'd0;
			ovld_q <= 1'b0;
		end else begin
			// In the done state the answer register is refilled below instead.
			if (ovld_q && out_ready && (st_q != ST_DONE)) ovld_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(TREE_NODES - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						isq_q  <= (cmd.op == lcmt_pkg::OP_QUERY);
						have_q <= 1'b0;
						i_q    <= qi;
						lx_q   <= '0;
						rx_q   <= leaves;
						x_q    <= '0;
						if (cmd.op != lcmt_pkg::OP_LOAD) st_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					st_q <= ST_FETCH2;
				end
				ST_FETCH2: begin
					st_q <= ST_FETCH3;
				end
				ST_FETCH3: begin
					ev_q <= 2'd0;
					ph_q <= 2'd0;
					st_q <= ST_EVAL;
				end
				ST_EVAL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						ev_q <= ev_q + 2'd1;
						if (ev_last) st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					have_q <= 1'b1;
					if (stop) begin
						st_q <= isq_q ? ST_DONE : ST_IDLE;
					end else begin
						x_q <= NW'(nx);
						if (go_right) lx_q <= m;
						else rx_q <= m;
						st_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					if (!ovld_q || out_ready) begin
						ovld_q <= 1'b1;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = odata_q;

endmodule
`default_nettype wire

@@ design/li_chao_line_min_tree.sv @@
// Top level of the line minimum tree: configuration registers, front, queue and walker.
`default_nettype none
// A tree of lines over a fixed ascending set of query points. A load request
// writes one point, an add request inserts the line slope*x + intercept, and
// a query request returns the lowest line value (highest in max mode) over
// the path from the root to the leaf of one point index; only queries give
// a result on the master side. Requests are taken by a front stage that
// drops requests which do nothing and negates lines in max mode, and wait in
// a two-entry queue for the walker. The walker handles one request at a
// time. A load is written to the point store from the idle state. An add or
// a query visits one tree level at a time, about log2(point_count)+1 levels;
// each level passes through the walk, fetch2 and fetch3 states for node and
// point memory reads, the evaluation state for each line evaluation on the
// shared 32x32 multiplier (four evaluations for an add, one for a query) and
// the decision state. After reset the walker clears the written flags of
// every node, one node a cycle; requests queue up meanwhile and configuration
// writes are taken at once. Configuration is to be written only while no
// request is in flight.
module li_chao_line_min_tree #(
	parameter int MAX_POINTS = 1024,
	parameter int TREE_NODES = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [1:0]   cfg_index,
	input  wire  [63:0]  cfg_data,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// point_index[9:0], point_value[73:10], slope[137:74], intercept[201:138]
	input  wire  [207:0] s_axis_tdata,
	// kind[1:0]
	input  wire  [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// answer[63:0]
	output logic [63:0]  m_axis_tdata
);

	logic             max_mode_q;
	logic [63:0]      neutral_q;
	logic [10:0]      point_count_q;
	lcmt_pkg::cfg_t   cfg;
	logic             push;
	lcmt_pkg::cmd_t   front_cmd;
	logic             push_ready;
	logic             q_valid;
	lcmt_pkg::cmd_t   q_cmd;
	logic             q_pop;

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mode_q    <= 1'b0;
			neutral_q     <= 64'h7FFF_FFFF_FFFF_FFFF;
			point_count_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				lcmt_pkg::REG_MAX_MODE:  max_mode_q    <= cfg_data[0];
				lcmt_pkg::REG_NEUTRAL:   neutral_q     <= cfg_data;
				lcmt_pkg::REG_POINT_CNT: point_count_q <= cfg_data[10:0];
				default: max_mode_q <= max_mode_q;
			endcase
		end
	end

	assign cfg.max_mode    = max_mode_q;
	assign cfg.neutral     = neutral_q;
	assign cfg.point_count = point_count_q;

	lcmt_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_mode  (max_mode_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_idx    (s_axis_tdata[9:0]),
		.in_value  (s_axis_tdata[73:10]),
		.in_slope  (s_axis_tdata[137:74]),
		.in_icpt   (s_axis_tdata[201:138]),
		.push      (push),
		.cmd       (front_cmd),
		.push_ready(push_ready)
	);

	lcmt_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (front_cmd),
		.ready (push_ready),
		.valid (q_valid),
		.dout  (q_cmd),
		.pop   (q_pop)
	);

	lcmt_back #(
		.MAX_POINTS(MAX_POINTS),
		.TREE_NODES(TREE_NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_valid(q_valid),
		.cmd      (q_cmd),
		.cmd_pop  (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule
`default_nettype wire
